/* rtl/i2cms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  // Command codes carried by req_type
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_LONG_HOLD  = 2'd0;
  localparam logic [1:0] REG_SHORT_HOLD = 2'd1;
  localparam logic [1:0] REG_ACK_LIMIT  = 2'd2;

  localparam int HOLD_W  = 10;
  localparam int LIMIT_W = 8;
  localparam int CFG_W   = 10;

  localparam logic [HOLD_W-1:0]  LONG_HOLD_RST  = 10'd10;
  localparam logic [HOLD_W-1:0]  SHORT_HOLD_RST = 10'd5;
  localparam logic [LIMIT_W-1:0] ACK_LIMIT_RST  = 8'd200;

  // Bits per byte
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Sequencer phase codes
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_SP_A    = 4'd3;
  localparam logic [3:0] PH_SP_B    = 4'd4;
  localparam logic [3:0] PH_AK_A    = 4'd5;
  localparam logic [3:0] PH_AK_B    = 4'd6;
  localparam logic [3:0] PH_WR_H    = 4'd7;
  localparam logic [3:0] PH_WR_L    = 4'd8;
  localparam logic [3:0] PH_WR_REL  = 4'd9;
  localparam logic [3:0] PH_WR_CLK  = 4'd10;
  localparam logic [3:0] PH_WR_FALL = 4'd11;
  localparam logic [3:0] PH_RD_H    = 4'd12;
  localparam logic [3:0] PH_RD_L    = 4'd13;
  localparam logic [3:0] PH_RD_END  = 4'd14;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } out_item_t;

  // A zero hold register behaves as a one-tick hold
  function automatic logic [HOLD_W-1:0] seg_hold(input logic [HOLD_W-1:0] h);
    seg_hold = (h == '0) ? HOLD_W'(1) : h;
  endfunction

endpackage

`default_nettype wire

/* rtl/i2cms_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface i2cms_in_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_out_if;
  logic                 valid;
  logic                 ready;
  i2cms_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/i2c_master_bit_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte-level I2C master sequencer. Every input transaction is one bus tick
// and may carry a command (start, stop, write byte, read byte, send ack);
// every input transaction yields exactly one result transaction with the
// SCL/SDA pin levels, SDA drive enable, busy, a one-tick done pulse, the
// last received byte and the no-ack flag. The block takes one tick per
// clock cycle: the whole tick update is a single pass of logic from the
// state registers into the result register, so the input side stays ready
// whenever the result register is empty or being drained. Hold lengths are
// in ticks (long/short hold registers, zero acts as one); after a written
// byte the slave ACK is re-sampled once per short hold up to the ack wait
// limit. Configuration is written through cfg_wr_en/cfg_index/cfg_data and
// must only change while no command is running.
module i2c_master_bit_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [i2cms_pkg::CFG_W-1:0] cfg_data,
  i2cms_in_if.sink                         in_ch,
  i2cms_out_if.source                      out_ch
);

  // Configuration registers
  logic [i2cms_pkg::HOLD_W-1:0]  long_hold;
  logic [i2cms_pkg::HOLD_W-1:0]  short_hold;
  logic [i2cms_pkg::LIMIT_W-1:0] ack_limit;

  // Sequencer state
  logic [3:0]                    phase,          phase_next;
  logic [2:0]                    active_command, active_command_next;
  logic [3:0]                    bit_index,      bit_index_next;
  logic [7:0]                    shift_reg,      shift_reg_next;
  logic [i2cms_pkg::HOLD_W-1:0]  hold_count,     hold_count_next;
  logic [i2cms_pkg::LIMIT_W-1:0] ack_wait_count, ack_wait_count_next;
  logic                          scl,            scl_next;
  logic                          sda,            sda_next;
  logic                          drive,          drive_next;
  logic                          no_ack_flag,    no_ack_flag_next;
  logic [7:0]                    rx_last,        rx_last_next;
  logic                          done;

  // Result register
  i2cms_pkg::out_item_t          out_q;
  logic                          out_valid;

  logic                          take;
  logic [i2cms_pkg::HOLD_W-1:0]  hold_dec;
  logic [3:0]                    bit_inc;
  logic [i2cms_pkg::HOLD_W-1:0]  long_seg;
  logic [i2cms_pkg::HOLD_W-1:0]  short_seg;
  i2cms_pkg::in_item_t           item;

  assign item         = in_ch.data;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

  assign long_seg  = i2cms_pkg::seg_hold(long_hold);
  assign short_seg = i2cms_pkg::seg_hold(short_hold);
  assign hold_dec  = (hold_count != '0) ? hold_count - 1'b1 : hold_count;
  assign bit_inc   = bit_index + 1'b1;

  // One tick of the sequencer
  always_comb begin
    phase_next          = phase;
    active_command_next = active_command;
    bit_index_next      = bit_index;
    shift_reg_next      = shift_reg;
    hold_count_next     = hold_count;
    ack_wait_count_next = ack_wait_count;
    scl_next            = scl;
    sda_next            = sda;
    drive_next          = drive;
    no_ack_flag_next    = no_ack_flag;
    rx_last_next        = rx_last;
    done                = 1'b0;

    if (phase == i2cms_pkg::PH_IDLE) begin
      // Idle: pick up a command; unknown codes fall through as no-ops
      unique case (item.req_type)
        i2cms_pkg::CMD_START: begin
          scl_next = 1'b1; sda_next = 1'b1; drive_next = 1'b1;
          phase_next = i2cms_pkg::PH_ST_A; hold_count_next = long_seg;
          active_command_next = item.req_type;
        end
        i2cms_pkg::CMD_STOP: begin
          sda_next = 1'b0; scl_next = 1'b1; drive_next = 1'b1;
          phase_next = i2cms_pkg::PH_SP_A; hold_count_next = long_seg;
          active_command_next = item.req_type;
        end
        i2cms_pkg::CMD_WRITE: begin
          shift_reg_next = item.tx_byte; bit_index_next = '0;
          ack_wait_count_next = '0; no_ack_flag_next = 1'b0;
          sda_next = item.tx_byte[7]; drive_next = 1'b1; scl_next = 1'b1;
          phase_next = i2cms_pkg::PH_WR_H; hold_count_next = long_seg;
          active_command_next = item.req_type;
        end
        i2cms_pkg::CMD_READ: begin
          shift_reg_next = '0; bit_index_next = '0;
          drive_next = 1'b0; scl_next = 1'b1;
          phase_next = i2cms_pkg::PH_RD_H; hold_count_next = short_seg;
          active_command_next = item.req_type;
        end
        i2cms_pkg::CMD_ACK: begin
          sda_next = item.ack_level; drive_next = 1'b1; scl_next = 1'b1;
          phase_next = i2cms_pkg::PH_AK_A; hold_count_next = long_seg;
          active_command_next = item.req_type;
        end
        default: ;
      endcase
    end else begin
      hold_count_next = hold_dec;
      if (hold_dec == '0) begin
        unique case (phase)
          i2cms_pkg::PH_ST_A: begin
            sda_next = 1'b0;
            phase_next = i2cms_pkg::PH_ST_B; hold_count_next = long_seg;
          end
          i2cms_pkg::PH_ST_B: begin
            scl_next = 1'b0; done = 1'b1;
          end
          i2cms_pkg::PH_SP_A: begin
            sda_next = 1'b1;
            phase_next = i2cms_pkg::PH_SP_B; hold_count_next = long_seg;
          end
          i2cms_pkg::PH_SP_B: done = 1'b1;
          i2cms_pkg::PH_AK_A: begin
            scl_next = 1'b0;
            phase_next = i2cms_pkg::PH_AK_B; hold_count_next = long_seg;
          end
          i2cms_pkg::PH_AK_B: done = 1'b1;
          i2cms_pkg::PH_WR_H: begin
            scl_next = 1'b0;
            phase_next = i2cms_pkg::PH_WR_L; hold_count_next = long_seg;
          end
          i2cms_pkg::PH_WR_L: begin
            bit_index_next = bit_inc;
            if (bit_inc < i2cms_pkg::BYTE_BITS) begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              sda_next = shift_reg[6];
              scl_next = 1'b1;
              phase_next = i2cms_pkg::PH_WR_H; hold_count_next = long_seg;
            end else begin
              drive_next = 1'b0;
              phase_next = i2cms_pkg::PH_WR_REL; hold_count_next = short_seg;
            end
          end
          i2cms_pkg::PH_WR_REL: begin
            scl_next = 1'b1;
            phase_next = i2cms_pkg::PH_WR_CLK; hold_count_next = short_seg;
          end
          i2cms_pkg::PH_WR_CLK: begin
            // ACK sampling: low SDA is an ack, else retry until the limit
            hold_count_next = short_seg;
            if (!item.sda_sample) begin
              scl_next = 1'b0;
              phase_next = i2cms_pkg::PH_WR_FALL;
            end else if (ack_wait_count < ack_limit) begin
              ack_wait_count_next = ack_wait_count + 1'b1;
            end else begin
              no_ack_flag_next = 1'b1;
              scl_next = 1'b0;
              phase_next = i2cms_pkg::PH_WR_FALL;
            end
          end
          i2cms_pkg::PH_WR_FALL: begin
            drive_next = 1'b1; done = 1'b1;
          end
          i2cms_pkg::PH_RD_H: begin
            shift_reg_next = {shift_reg[6:0], item.sda_sample};
            scl_next = 1'b0;
            phase_next = i2cms_pkg::PH_RD_L; hold_count_next = long_seg;
          end
          i2cms_pkg::PH_RD_L: begin
            bit_index_next = bit_inc;
            if (bit_inc < i2cms_pkg::BYTE_BITS) begin
              scl_next = 1'b1;
              phase_next = i2cms_pkg::PH_RD_H; hold_count_next = short_seg;
            end else begin
              drive_next = 1'b1;
              phase_next = i2cms_pkg::PH_RD_END; hold_count_next = long_seg;
            end
          end
          i2cms_pkg::PH_RD_END: begin
            rx_last_next = shift_reg; done = 1'b1;
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          phase_next          = i2cms_pkg::PH_IDLE;
          active_command_next = i2cms_pkg::CMD_NONE;
          hold_count_next     = '0;
        end
      end
    end
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      long_hold  <= i2cms_pkg::LONG_HOLD_RST;
      short_hold <= i2cms_pkg::SHORT_HOLD_RST;
      ack_limit  <= i2cms_pkg::ACK_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        i2cms_pkg::REG_LONG_HOLD:  long_hold  <= cfg_data;
        i2cms_pkg::REG_SHORT_HOLD: short_hold <= cfg_data;
        i2cms_pkg::REG_ACK_LIMIT:  ack_limit  <= cfg_data[i2cms_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // State advances only on an accepted tick transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= i2cms_pkg::PH_IDLE;
      active_command <= i2cms_pkg::CMD_NONE;
      bit_index      <= '0;
      shift_reg      <= '0;
      hold_count     <= '0;
      ack_wait_count <= '0;
      scl            <= 1'b1;
      sda            <= 1'b1;
      drive          <= 1'b1;
      no_ack_flag    <= 1'b0;
      rx_last        <= '0;
    end else if (take) begin
      phase          <= phase_next;
      active_command <= active_command_next;
      bit_index      <= bit_index_next;
      shift_reg      <= shift_reg_next;
      hold_count     <= hold_count_next;
      ack_wait_count <= ack_wait_count_next;
      scl            <= scl_next;
      sda            <= sda_next;
      drive          <= drive_next;
      no_ack_flag    <= no_ack_flag_next;
      rx_last        <= rx_last_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_q.scl_level <= scl_next;
      out_q.sda_level <= sda_next;
      out_q.sda_drive <= drive_next;
      out_q.busy_res  <= (phase_next != i2cms_pkg::PH_IDLE);
      out_q.done_res  <= done;
      out_q.rx_byte   <= rx_last_next;
      out_q.no_ack    <= no_ack_flag_next;
    end
  end

`ifndef ASSERT_OFF
  // A running command always has a live hold count; idle holds none
  a_hold_live: assert property (@(posedge clk) disable iff (rst)
    (phase != i2cms_pkg::PH_IDLE) == (hold_count != '0))
    else $error("hold count out of step with phase");

  // Active command register tracks busy
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (phase == i2cms_pkg::PH_IDLE) == (active_command == i2cms_pkg::CMD_NONE))
    else $error("active command out of step with phase");

  // The finishing tick never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.done_res |-> !out_q.busy_res)
    else $error("done reported while busy");

  // Bit counter never runs past one byte
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= i2cms_pkg::BYTE_BITS)
    else $error("bit index past byte length");
`endif

endmodule

`default_nettype wire
